// File: rtl/rlfs_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED frame store package
// Shared types and constants for the LED colour store.
// ----------------------------------------------------------------------------
package rlfs_pkg;

    localparam int LED_COUNT = 25;
    localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam logic [7:0]  LEVEL_FULL  = 8'hFF;
    localparam logic [23:0] COLOUR_WHITE = {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic [1:0] PH_INDEX = 2'd0;
    localparam logic [1:0] PH_RED   = 2'd1;
    localparam logic [1:0] PH_GREEN = 2'd2;
    localparam logic [1:0] PH_BLUE  = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [4:0] led_number;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic       last_led;
    } result_t;

endpackage

// File: rtl/rgb_led_frame_store.sv
// ----------------------------------------------------------------------------
// RGB LED frame store
// Collects four-byte records (index, red, green, blue) into a colour table
// held in a synchronous memory and streams the table out on a refresh tick.
//
// An item is taken at a clock edge where start is high and busy is low.
// A data byte (opcode 0) gives no result; data bytes may follow each other
// in every cycle while busy is low. The fourth byte of a record writes the
// colour memory, unless the index is out of range.
// A refresh tick (opcode 1) holds busy high while the memory is read, one
// entry per cycle, from entry 0 to the last. Each result appears in the cycle after
// its read, for exactly one cycle, marked by result_valid, in ascending LED
// order, with last_led set on the final one. Busy falls once the last entry
// has been read, so the next item can be taken while the last result is
// still shown.
// Reset clears the record phase, the held bytes and one valid bit per entry;
// an entry that was never written reads as white. The receiver cannot stall
// results, so no output buffering beyond one register stage is needed.
// ----------------------------------------------------------------------------
module rgb_led_frame_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rlfs_pkg::cmd_t    cmd,
    output logic             result_valid,
    output rlfs_pkg::result_t result
);
    import rlfs_pkg::*;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [1:0]             phase_reg;
    logic [7:0]             held_index_reg;
    logic [7:0]             held_red_reg;
    logic [7:0]             held_green_reg;
    logic [LED_COUNT-1:0]   valid_reg;
    logic [23:0]            colour_mem [LED_COUNT];
    logic [23:0]            rd_data_reg;
    logic                   pipe_valid_reg;
    logic                   pipe_entry_valid_reg;
    logic [IDX_W-1:0]       pipe_idx_reg;
    logic                   pipe_last_reg;
    logic                   accept;
    logic                   data_accept;
    logic                   mem_we;
    logic                   rd_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [23:0]            colour_out;

    assign accept         = start && !busy;
    assign data_accept    = accept && (cmd.opcode == OP_DATA);
    assign mem_we         = data_accept && (phase_reg == PH_BLUE)
                            && (held_index_reg < 8'(LED_COUNT));
    assign wr_addr        = held_index_reg[IDX_W-1:0];
    assign rd_en          = (state_reg == ST_STREAM);

    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        busy        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (cmd.opcode == OP_REFRESH))
                begin
                    state_next  = ST_STREAM;
                    rd_idx_next = '0;
                end
            end
            ST_STREAM:
            begin
                busy = 1'b1;
                if (rd_idx_reg == IDX_W'(LED_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            rd_idx_reg           <= '0;
            phase_reg            <= PH_INDEX;
            held_index_reg       <= '0;
            held_red_reg         <= '0;
            held_green_reg       <= '0;
            valid_reg            <= '0;
            pipe_valid_reg       <= 1'b0;
            pipe_entry_valid_reg <= 1'b0;
            pipe_idx_reg         <= '0;
            pipe_last_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            pipe_valid_reg <= rd_en;
            if (rd_en)
            begin
                pipe_entry_valid_reg <= valid_reg[rd_idx_reg];
                pipe_idx_reg         <= rd_idx_reg;
                pipe_last_reg        <= (rd_idx_reg == IDX_W'(LED_COUNT - 1));
            end
            if (data_accept)
            begin
                phase_reg <= phase_reg + 2'd1;
                case (phase_reg)
                    PH_INDEX: held_index_reg <= cmd.data_byte;
                    PH_RED:   held_red_reg   <= cmd.data_byte;
                    PH_GREEN: held_green_reg <= cmd.data_byte;
                    default:  ;
                endcase
            end
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            colour_mem[wr_addr] <= {held_red_reg, held_green_reg, cmd.data_byte};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= colour_mem[rd_idx_reg];
        end
    end

    assign colour_out         = pipe_entry_valid_reg ? rd_data_reg : COLOUR_WHITE;
    assign result_valid       = pipe_valid_reg;
    assign result.led_number  = 5'(pipe_idx_reg);
    assign result.red_level   = colour_out[23:16];
    assign result.green_level = colour_out[15:8];
    assign result.blue_level  = colour_out[7:0];
    assign result.last_led    = pipe_last_reg;

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_led) |=> !result_valid)
        else $error("result follows the last LED of a run");

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_led) |=> result_valid)
        else $error("refresh run has a gap");

    a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !$past(result_valid)) |-> (result.led_number == 5'd0))
        else $error("refresh run does not start at LED zero");

    a_refresh_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == OP_REFRESH)) |=> busy)
        else $error("refresh tick did not start a read run");

endmodule
